// File: hdl/srhm_pkg.sv
// package for the sensor rate and health monitor
// types, codes, field widths and reset values shared by the srhm front, back and top modules
// no dependencies
package srhm_pkg;

  localparam int unsigned DefWindowDepth = 256;
  localparam int unsigned DefSensorCount = 4;
  localparam int unsigned DefTimeBits    = 48;

  localparam int unsigned PeriodW  = 34;
  localparam int unsigned FracW    = 9;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 34;
  localparam int unsigned SelW     = 2;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned StatW    = 2;
  localparam int unsigned ReasonW  = 3;
  localparam int unsigned OutCntW  = 9;
  localparam int unsigned ErrW     = 9;
  localparam int unsigned CauseW   = 2;
  localparam int unsigned Q8Shift  = 8;

  localparam logic [PeriodW-1:0] WindowReset   = 34'd1000000000;
  localparam logic [FracW-1:0]   HealthyReset  = 9'd205;
  localparam logic [FracW-1:0]   DegradedReset = 9'd128;
  localparam logic [PeriodW-1:0] GraceReset    = 34'd2000000000;
  localparam logic [ErrW-1:0]    Q8One         = 9'd256;
  localparam logic [OutCntW-1:0] OutCntMax     = 9'd511;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW   = 3'd0,
    CFG_HEALTHY  = 3'd1,
    CFG_DEGRADED = 3'd2,
    CFG_GRACE    = 3'd3,
    CFG_PERIOD0  = 3'd4,
    CFG_PERIOD1  = 3'd5,
    CFG_PERIOD2  = 3'd6,
    CFG_PERIOD3  = 3'd7
  } cfg_idx_e;

  typedef enum logic [StatW-1:0] {
    ST_UNKNOWN  = 2'd0,
    ST_HEALTHY  = 2'd1,
    ST_DEGRADED = 2'd2,
    ST_FAULT    = 2'd3
  } status_e;

  typedef enum logic [ReasonW-1:0] {
    RS_NONE_SEEN   = 3'd0,
    RS_NORMAL      = 3'd1,
    RS_DEGRADED    = 3'd2,
    RS_RATE_LOW    = 3'd3,
    RS_AGE_HIGH    = 3'd4,
    RS_ALL_UNKNOWN = 3'd5
  } reason_e;

  typedef enum logic {
    KIND_ARRIVE = 1'b0,
    KIND_TICK   = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PR_CHECK,
    BK_PR_CMP,
    BK_EV_MUL,
    BK_EV_DIV,
    BK_EV_EMIT,
    BK_SUMMARY
  } back_state_e;

  function automatic logic [PeriodW-1:0] period_reset(input int unsigned idx);
    logic [PeriodW-1:0] val;
    case (idx)
      0:       val = 34'd100000000;
      1:       val = 34'd10000000;
      2:       val = 34'd100000000;
      3:       val = 34'd20000000;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// File: hdl/srhm_ram.sv
// generic simple dual-port ram with registered read
// depends on nothing
module srhm_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/srhm_fifo.sv
// small register fifo used between front and back and on the result side
// depends on nothing
module srhm_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// File: hdl/srhm_front.sv
// front end: takes input transactions, drops the ones with no effect and
// works out the prune cutoff; depends on srhm_pkg
module srhm_front #(
  parameter int unsigned SensorCount = srhm_pkg::DefSensorCount,
  parameter int unsigned TimeBits    = srhm_pkg::DefTimeBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic                         mode_i,
  input  logic [srhm_pkg::SelW-1:0]    sel_i,
  input  logic [TimeBits-1:0]          now_i,
  input  logic [srhm_pkg::PeriodW-1:0] grace_i,
  input  logic [srhm_pkg::PeriodW-1:0] win_i,
  output logic                         cmd_valid_o,
  output logic [2*TimeBits+srhm_pkg::SelW:0] cmd_o,
  input  logic                         cmd_full_i
);
  import srhm_pkg::*;

  localparam int unsigned CmdW = 2 * TimeBits + SelW + 1;
  localparam int unsigned GW   = (TimeBits > PeriodW) ? TimeBits : PeriodW;

  logic            valid_q, valid_d;
  logic [CmdW-1:0] cmd_q, cmd_d;
  logic            ready, accept, keep;
  kind_e           kind;
  logic [TimeBits-1:0] cutoff;

  assign ready  = !valid_q || !cmd_full_i;
  assign full_o = !ready;
  assign accept = push_i && ready;
  assign kind   = mode_i ? KIND_TICK : KIND_ARRIVE;

  always_comb begin
    if (kind == KIND_TICK) begin
      // ticks inside the startup grace time do nothing
      keep = !(GW'(now_i) < GW'(grace_i));
    end else begin
      keep = (32'(sel_i) < SensorCount);
    end
    if (GW'(now_i) >= GW'(win_i)) begin
      cutoff = TimeBits'(GW'(now_i) - GW'(win_i));
    end else begin
      cutoff = '0;
    end
  end

  always_comb begin
    valid_d = valid_q && cmd_full_i;
    cmd_d   = cmd_q;
    if (accept && keep) begin
      valid_d = 1'b1;
      cmd_d   = {kind, sel_i, cutoff, now_i};
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// File: hdl/srhm_back.sv
// back end: keeps the arrival rings, prunes and grades each sensor on a tick
// depends on srhm_pkg and srhm_ram
module srhm_back #(
  parameter int unsigned WindowDepth = srhm_pkg::DefWindowDepth,
  parameter int unsigned SensorCount = srhm_pkg::DefSensorCount,
  parameter int unsigned TimeBits    = srhm_pkg::DefTimeBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  logic [2*TimeBits+srhm_pkg::SelW:0] cmd_i,
  output logic                         cmd_pop_o,
  input  logic [srhm_pkg::PeriodW-1:0] win_i,
  input  logic [srhm_pkg::FracW-1:0]   healthy_i,
  input  logic [srhm_pkg::FracW-1:0]   degraded_i,
  input  logic [SensorCount-1:0][srhm_pkg::PeriodW-1:0] period_i,
  input  logic                         res_full_i,
  output logic                         res_push_o,
  output logic [TimeBits+28:0]         res_o
);
  import srhm_pkg::*;

  localparam int unsigned HeadW   = $clog2(WindowDepth);
  localparam int unsigned CntW    = $clog2(WindowDepth + 1);
  localparam int unsigned SIdxW   = (SensorCount > 1) ? $clog2(SensorCount) : 1;
  localparam int unsigned SCntW   = $clog2(SensorCount + 1);
  localparam int unsigned AddrW   = SIdxW + HeadW;
  localparam int unsigned RamDepth = 1 << AddrW;
  localparam int unsigned NumW    = CntW + PeriodW + Q8Shift;
  localparam int unsigned BitW    = $clog2(NumW + 1);
  localparam int unsigned CmpW    = (TimeBits > PeriodW + 3) ? TimeBits : PeriodW + 3;

  back_state_e state_q, state_d;
  logic [SCntW-1:0]    s_q, s_d;
  logic [HeadW-1:0]    head_q [SensorCount];
  logic [HeadW-1:0]    head_d [SensorCount];
  logic [CntW-1:0]     count_q [SensorCount];
  logic [CntW-1:0]     count_d [SensorCount];
  logic [TimeBits-1:0] last_q [SensorCount];
  logic [TimeBits-1:0] last_d [SensorCount];
  logic [SensorCount-1:0] seen_q, seen_d;
  logic [TimeBits-1:0] now_q, now_d, cutoff_q, cutoff_d, age_q, age_d;
  logic [NumW-1:0]     num_q, num_d;
  logic [PeriodW-1:0]  rem_q, rem_d;
  logic [FracW-1:0]    quot_q, quot_d;
  logic                ovf_q, ovf_d;
  logic [BitW-1:0]     bit_q, bit_d;
  status_e             worst_q, worst_d;
  reason_e             worst_rs_q, worst_rs_d;
  logic [CauseW-1:0]   cause_q, cause_d;

  kind_e               cmd_kind;
  logic [SelW-1:0]     cmd_sel;
  logic [TimeBits-1:0] cmd_cutoff, cmd_now;
  logic [SIdxW-1:0]    si, ai;
  logic [CntW:0]       pos_sum;
  logic [HeadW-1:0]    pos;

  logic                ram_we, ram_re;
  logic [AddrW-1:0]    ram_waddr, ram_raddr;
  logic [TimeBits-1:0] ram_rdata;

  logic [PeriodW:0]    rem_try;
  logic                rem_ge;
  logic [FracW:0]      ratio;
  logic [PeriodW-1:0]  per;
  status_e             st;
  reason_e             rs;
  logic [ErrW-1:0]     err;
  logic [OutCntW-1:0]  cnt_out;
  logic [TimeBits-1:0] age_out;

  assign {cmd_kind, cmd_sel, cmd_cutoff, cmd_now} = cmd_i;
  assign si      = s_q[SIdxW-1:0];
  assign ai      = SIdxW'(cmd_sel);
  assign pos_sum = (CntW + 1)'(head_q[ai]) + (CntW + 1)'(count_q[ai]);
  assign pos     = (pos_sum >= (CntW + 1)'(WindowDepth)) ?
                   HeadW'(pos_sum - (CntW + 1)'(WindowDepth)) : HeadW'(pos_sum);

  srhm_ram #(
    .Width (TimeBits),
    .Depth (RamDepth)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_now),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // grading of the current sensor from the finished quotient
  always_comb begin
    per     = period_i[si];
    ratio   = {ovf_q, quot_q};
    cnt_out = (32'(count_q[si]) > 32'(OutCntMax)) ? OutCntMax : OutCntW'(count_q[si]);
    if (!seen_q[si]) begin
      st      = ST_UNKNOWN;
      rs      = RS_NONE_SEEN;
      err     = Q8One;
      age_out = '0;
    end else begin
      age_out = age_q;
      if (per == '0) begin
        err = '0;
      end else if (ratio >= (FracW + 1)'(Q8One)) begin
        err = '0;
      end else begin
        err = ErrW'((FracW + 1)'(Q8One) - ratio);
      end
      if (ratio >= (FracW + 1)'(healthy_i) &&
          CmpW'(age_q) < (CmpW'(per) << 1)) begin
        st = ST_HEALTHY;
        rs = RS_NORMAL;
      end else if (ratio >= (FracW + 1)'(degraded_i) &&
                   CmpW'(age_q) < ((CmpW'(per) << 2) + CmpW'(per))) begin
        st = ST_DEGRADED;
        rs = RS_DEGRADED;
      end else begin
        st = ST_FAULT;
        rs = (ratio < (FracW + 1)'(degraded_i)) ? RS_RATE_LOW : RS_AGE_HIGH;
      end
    end
  end

  assign rem_try = {rem_q, num_q[NumW-1]};
  assign rem_ge  = (rem_try >= (PeriodW + 1)'(win_i));

  always_comb begin
    state_d    = state_q;
    s_d        = s_q;
    head_d     = head_q;
    count_d    = count_q;
    last_d     = last_q;
    seen_d     = seen_q;
    now_d      = now_q;
    cutoff_d   = cutoff_q;
    age_d      = age_q;
    num_d      = num_q;
    rem_d      = rem_q;
    quot_d     = quot_q;
    ovf_d      = ovf_q;
    bit_d      = bit_q;
    worst_d    = worst_q;
    worst_rs_d = worst_rs_q;
    cause_d    = cause_q;
    cmd_pop_o  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = {ai, pos};
    ram_re     = 1'b0;
    ram_raddr  = {si, head_q[si]};
    res_push_o = 1'b0;
    res_o      = {IdxW'(s_q), st, rs, cnt_out, age_out, err, CauseW'(0), 1'b0};

    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_kind == KIND_ARRIVE) begin
            ram_we     = 1'b1;
            last_d[ai] = cmd_now;
            seen_d[ai] = 1'b1;
            if (count_q[ai] < CntW'(WindowDepth)) begin
              count_d[ai] = count_q[ai] + 1'b1;
            end else begin
              // ring full: oldest stamp goes
              head_d[ai] = (head_q[ai] == HeadW'(WindowDepth - 1)) ?
                           '0 : head_q[ai] + 1'b1;
            end
          end else begin
            now_d      = cmd_now;
            cutoff_d   = cmd_cutoff;
            s_d        = '0;
            worst_d    = ST_UNKNOWN;
            worst_rs_d = RS_ALL_UNKNOWN;
            cause_d    = '0;
            state_d    = BK_PR_CHECK;
          end
        end
      end
      BK_PR_CHECK: begin
        if (s_q == SCntW'(SensorCount)) begin
          s_d     = '0;
          state_d = BK_EV_MUL;
        end else if (count_q[si] == '0) begin
          s_d = s_q + 1'b1;
        end else begin
          ram_re  = 1'b1;
          state_d = BK_PR_CMP;
        end
      end
      BK_PR_CMP: begin
        if (ram_rdata < cutoff_q) begin
          head_d[si]  = (head_q[si] == HeadW'(WindowDepth - 1)) ?
                        '0 : head_q[si] + 1'b1;
          count_d[si] = count_q[si] - 1'b1;
        end else begin
          s_d = s_q + 1'b1;
        end
        state_d = BK_PR_CHECK;
      end
      BK_EV_MUL: begin
        num_d   = (NumW'(count_q[si]) * NumW'(per)) << Q8Shift;
        age_d   = (now_q >= last_q[si]) ? now_q - last_q[si] : '0;
        rem_d   = '0;
        quot_d  = '0;
        ovf_d   = 1'b0;
        bit_d   = BitW'(NumW);
        state_d = BK_EV_DIV;
      end
      BK_EV_DIV: begin
        // restoring division, one quotient bit per cycle, saturating
        rem_d  = rem_ge ? PeriodW'(rem_try - (PeriodW + 1)'(win_i)) : PeriodW'(rem_try);
        quot_d = {quot_q[FracW-2:0], rem_ge};
        ovf_d  = ovf_q | quot_q[FracW-1];
        num_d  = num_q << 1;
        bit_d  = bit_q - 1'b1;
        if (bit_q == BitW'(1)) begin
          state_d = BK_EV_EMIT;
        end
      end
      BK_EV_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (st > worst_q) begin
            worst_d    = st;
            worst_rs_d = rs;
            cause_d    = CauseW'(s_q);
          end
          s_d     = s_q + 1'b1;
          state_d = (s_q + 1'b1 == SCntW'(SensorCount)) ? BK_SUMMARY : BK_EV_MUL;
        end
      end
      BK_SUMMARY: begin
        res_o = {IdxW'(SensorCount), worst_q, worst_rs_q, OutCntW'(0),
                 TimeBits'(0), ErrW'(0), cause_q, 1'b1};
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      s_q        <= '0;
      seen_q     <= '0;
      worst_q    <= ST_UNKNOWN;
      worst_rs_q <= RS_ALL_UNKNOWN;
      cause_q    <= '0;
      for (int i = 0; i < SensorCount; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
        last_q[i]  <= '0;
      end
    end else begin
      state_q    <= state_d;
      s_q        <= s_d;
      seen_q     <= seen_d;
      worst_q    <= worst_d;
      worst_rs_q <= worst_rs_d;
      cause_q    <= cause_d;
      head_q     <= head_d;
      count_q    <= count_d;
      last_q     <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q    <= now_d;
    cutoff_q <= cutoff_d;
    age_q    <= age_d;
    num_q    <= num_d;
    rem_q    <= rem_d;
    quot_q   <= quot_d;
    ovf_q    <= ovf_d;
    bit_q    <= bit_d;
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i) else $error("result pushed into full queue");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == BK_IDLE) && cmd_valid_i)
    else $error("command taken outside idle");

  a_prune_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_PR_CMP |-> count_q[si] != '0)
    else $error("prune compare on empty ring");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_EV_EMIT |-> bit_q == '0)
    else $error("grading before division finished");

endmodule

// File: hdl/sensor_rate_health_monitor.sv
// sensor rate and health monitor, top level
// an arrival passes the front register and the command fifo before the back end stores it; a
// tick takes the same path, then runs a prune pass (a ring read and compare per stamp, a check
// per sensor left empty, one to finish), then per sensor a multiply, the bit-serial ratio divider
// and a result push, which waits while the result queue is full; arrivals sustain one per cycle
// while no tick is in progress; reset restores config defaults, control, counts and seen flags
module sensor_rate_health_monitor #(
  parameter int unsigned WindowDepth = srhm_pkg::DefWindowDepth,
  parameter int unsigned SensorCount = srhm_pkg::DefSensorCount,
  parameter int unsigned TimeBits    = srhm_pkg::DefTimeBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          mode_i,
  input  logic [srhm_pkg::SelW-1:0]     sensor_select_i,
  input  logic [TimeBits-1:0]           now_time_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [srhm_pkg::IdxW-1:0]     report_index_o,
  output logic [srhm_pkg::StatW-1:0]    status_o,
  output logic [srhm_pkg::ReasonW-1:0]  reason_o,
  output logic [srhm_pkg::OutCntW-1:0]  msg_count_o,
  output logic [TimeBits-1:0]           data_age_o,
  output logic [srhm_pkg::ErrW-1:0]     miss_rate_o,
  output logic [srhm_pkg::CauseW-1:0]   cause_sensor_o,
  output logic                          last_of_run_o,
  input  logic                          cfg_we_i,
  input  logic [srhm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [srhm_pkg::CfgDataW-1:0] cfg_data_i
);
  import srhm_pkg::*;

  localparam int unsigned CmdW = 2 * TimeBits + SelW + 1;
  localparam int unsigned ResW = TimeBits + 29;

  logic [PeriodW-1:0] window_q, grace_q, win_eff;
  logic [FracW-1:0]   healthy_q, degraded_q;
  logic [SensorCount-1:0][PeriodW-1:0] period_q;

  logic            fr_valid, cq_full, cq_empty, bk_pop;
  logic [CmdW-1:0] fr_cmd, cq_cmd;
  logic            res_push, res_full;
  logic [ResW-1:0] res_wdata, res_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= WindowReset;
      healthy_q  <= HealthyReset;
      degraded_q <= DegradedReset;
      grace_q    <= GraceReset;
      for (int i = 0; i < SensorCount; i++) begin
        period_q[i] <= period_reset(i);
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WINDOW:   window_q   <= cfg_data_i;
        CFG_HEALTHY:  healthy_q  <= FracW'(cfg_data_i);
        CFG_DEGRADED: degraded_q <= FracW'(cfg_data_i);
        CFG_GRACE:    grace_q    <= cfg_data_i;
        default: begin
          for (int i = 0; i < SensorCount; i++) begin
            if (32'(cfg_index_i) == 32'(CFG_PERIOD0) + i) begin
              period_q[i] <= cfg_data_i;
            end
          end
        end
      endcase
    end
  end

  // a zero window behaves as one nanosecond
  assign win_eff = (window_q == '0) ? PeriodW'(1) : window_q;

  srhm_front #(
    .SensorCount (SensorCount),
    .TimeBits    (TimeBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .mode_i      (mode_i),
    .sel_i       (sensor_select_i),
    .now_i       (now_time_i),
    .grace_i     (grace_q),
    .win_i       (win_eff),
    .cmd_valid_o (fr_valid),
    .cmd_o       (fr_cmd),
    .cmd_full_i  (cq_full)
  );

  srhm_fifo #(
    .Width (CmdW),
    .Depth (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .wdata_i (fr_cmd),
    .full_o  (cq_full),
    .pop_i   (bk_pop),
    .rdata_o (cq_cmd),
    .empty_o (cq_empty)
  );

  srhm_back #(
    .WindowDepth (WindowDepth),
    .SensorCount (SensorCount),
    .TimeBits    (TimeBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cq_empty),
    .cmd_i       (cq_cmd),
    .cmd_pop_o   (bk_pop),
    .win_i       (win_eff),
    .healthy_i   (healthy_q),
    .degraded_i  (degraded_q),
    .period_i    (period_q),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_wdata)
  );

  srhm_fifo #(
    .Width (ResW),
    .Depth (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wdata),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign {report_index_o, status_o, reason_o, msg_count_o, data_age_o,
          miss_rate_o, cause_sensor_o, last_of_run_o} = res_rdata;

endmodule

// File: tb/tb.sv
// self-checking testbench for sensor_rate_health_monitor
// predicts every report with its own model of the monitor and checks each result transaction
// depends on hdl/srhm_pkg.sv and hdl/sensor_rate_health_monitor.sv
`timescale 1ns / 1ps

module tb;
  import srhm_pkg::*;

  localparam int unsigned Depth = 256;
  localparam int unsigned Sensors = 4;
  localparam longint unsigned CycleLimit = 1000000;
  localparam longint unsigned TimeMax = 48'hFFFF_FFFF_FFFF;
  localparam longint unsigned RegMax = 34'h3_FFFF_FFFF;

  typedef struct packed {
    logic [IdxW-1:0]    idx;
    status_e            st;
    reason_e            rs;
    logic [OutCntW-1:0] cnt;
    logic [47:0]        age;
    logic [ErrW-1:0]    err;
    logic [CauseW-1:0]  cause;
    logic               last;
  } health_report_t;

  class health_scoreboard;
    logic [47:0] stamps[Sensors][Depth];
    int unsigned head[Sensors];
    int unsigned fill[Sensors];
    longint unsigned last_seen_at[Sensors];
    bit seen[Sensors];
    longint unsigned win_len_ns, grace_ns, healthy_q8, degraded_q8;
    longint unsigned period_ns[Sensors];
    health_report_t reports_due[$];
    int errors;

    function new();
      win_len_ns = WindowReset;
      healthy_q8 = HealthyReset;
      degraded_q8 = DegradedReset;
      grace_ns = GraceReset;
      for (int s = 0; s < Sensors; s++) begin
        period_ns[s] = period_reset(s);
        head[s] = 0;
        fill[s] = 0;
        last_seen_at[s] = 0;
        seen[s] = 0;
      end
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, longint unsigned val);
      case (idx)
        CFG_WINDOW:   win_len_ns = val & RegMax;
        CFG_HEALTHY:  healthy_q8 = val & 9'h1FF;
        CFG_DEGRADED: degraded_q8 = val & 9'h1FF;
        CFG_GRACE:    grace_ns = val & RegMax;
        CFG_PERIOD0:  period_ns[0] = val & RegMax;
        CFG_PERIOD1:  period_ns[1] = val & RegMax;
        CFG_PERIOD2:  period_ns[2] = val & RegMax;
        default:      period_ns[3] = val & RegMax;
      endcase
    endfunction

    function int pending();
      return reports_due.size();
    endfunction

    function void note_input(kind_e kind, int unsigned sel, longint unsigned now);
      longint unsigned win, cutoff, p, ratio, age;
      health_report_t r;
      status_e worst;
      reason_e worst_rs;
      int unsigned cause;
      if (kind == KIND_ARRIVE) begin
        last_seen_at[sel] = now;
        seen[sel] = 1;
        stamps[sel][(head[sel] + fill[sel]) % Depth] = 48'(now);
        if (fill[sel] < Depth) fill[sel]++;
        else head[sel] = (head[sel] + 1) % Depth;
        return;
      end
      if (now < grace_ns) return;
      win = (win_len_ns == 0) ? 1 : win_len_ns;
      cutoff = (now >= win) ? now - win : 0;
      for (int s = 0; s < Sensors; s++)
        while (fill[s] > 0 && stamps[s][head[s]] < cutoff) begin
          head[s] = (head[s] + 1) % Depth;
          fill[s]--;
        end
      worst = ST_UNKNOWN;
      worst_rs = RS_ALL_UNKNOWN;
      cause = 0;
      for (int s = 0; s < Sensors; s++) begin
        r = '0;
        r.idx = IdxW'(s);
        r.cnt = OutCntW'(fill[s]);
        if (!seen[s]) begin
          r.st = ST_UNKNOWN;
          r.rs = RS_NONE_SEEN;
          r.err = Q8One;
        end else begin
          p = period_ns[s];
          age = (now >= last_seen_at[s]) ? now - last_seen_at[s] : 0;
          r.age = 48'(age);
          ratio = (fill[s] * p * 256) / win;
          r.err = (p == 0) ? '0 : ErrW'(256 - ((ratio > 256) ? 256 : ratio));
          if (ratio >= healthy_q8 && age < 2 * p) begin
            r.st = ST_HEALTHY;
            r.rs = RS_NORMAL;
          end else if (ratio >= degraded_q8 && age < 5 * p) begin
            r.st = ST_DEGRADED;
            r.rs = RS_DEGRADED;
          end else begin
            r.st = ST_FAULT;
            r.rs = (ratio < degraded_q8) ? RS_RATE_LOW : RS_AGE_HIGH;
          end
        end
        reports_due.insert(reports_due.size(), r);
        if (r.st > worst) begin
          worst = r.st;
          worst_rs = r.rs;
          cause = s;
        end
      end
      r = '0;
      r.idx = IdxW'(Sensors);
      r.st = worst;
      r.rs = worst_rs;
      r.cause = CauseW'(cause);
      r.last = 1'b1;
      reports_due.insert(reports_due.size(), r);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(health_report_t got);
      health_report_t exp;
      if (reports_due.size() == 0) begin
        report($sformatf("unexpected report for index %0d", got.idx));
        return;
      end
      exp = reports_due[0];
      reports_due.delete(0);
      if (got.idx !== exp.idx)
        report($sformatf("report_index %0d, want %0d", got.idx, exp.idx));
      if (got.st !== exp.st)
        report($sformatf("index %0d status %0d, want %0d", exp.idx, got.st, exp.st));
      if (got.rs !== exp.rs)
        report($sformatf("index %0d reason %0d, want %0d", exp.idx, got.rs, exp.rs));
      if (got.cnt !== exp.cnt)
        report($sformatf("index %0d msg_count %0d, want %0d", exp.idx, got.cnt, exp.cnt));
      if (got.age !== exp.age)
        report($sformatf("index %0d data_age %0d, want %0d", exp.idx, got.age, exp.age));
      if (got.err !== exp.err)
        report($sformatf("index %0d miss rate %0d, want %0d", exp.idx, got.err, exp.err));
      if (got.cause !== exp.cause)
        report($sformatf("index %0d cause %0d, want %0d", exp.idx, got.cause, exp.cause));
      if (got.last !== exp.last)
        report($sformatf("index %0d last_of_run %0b, want %0b", exp.idx, got.last, exp.last));
    endtask
  endclass

  logic clk_i, rst_ni, push, full, empty, pop, cfg_we_i;
  logic mode_i, last_of_run_o;
  logic [SelW-1:0]     sensor_select_i;
  logic [47:0]         now_time_i, data_age_o;
  logic [IdxW-1:0]     report_index_o;
  logic [StatW-1:0]    status_o;
  logic [ReasonW-1:0]  reason_o;
  logic [OutCntW-1:0]  msg_count_o;
  logic [ErrW-1:0]     miss_rate_o;
  logic [CauseW-1:0]   cause_sensor_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  health_scoreboard sb = new();
  longint unsigned cycle_count = 0;
  longint unsigned clock_ns = 0;

  sensor_rate_health_monitor u_dut (
    .clk_i, .rst_ni, .push, .full, .mode_i, .sensor_select_i, .now_time_i,
    .empty, .pop, .report_index_o, .status_o, .reason_o, .msg_count_o,
    .data_age_o, .miss_rate_o, .cause_sensor_o, .last_of_run_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // idle-free stretches: no gap is drawn in every third block of the cycle counter
  function automatic int draw_gap();
    return ((cycle_count / 500) % 3 == 0) ? 0 : $urandom_range(4);
  endfunction

  task automatic send_item(kind_e kind, int unsigned sel, longint unsigned now);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    mode_i <= kind;
    sensor_select_i <= SelW'(sel);
    now_time_i <= 48'(now);
    do @(posedge clk_i); while (full);
    sb.note_input(kind, sel, now & TimeMax);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, longint unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CfgDataW'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic random_items(int n, int tick_odds, int step_max, int favour);
    int r;
    int unsigned sel;
    longint unsigned now;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 5) begin
        now = {$urandom, $urandom} & TimeMax;
      end else if (r < 9) begin
        now = clock_ns - $urandom_range(step_max * 3);
      end else begin
        clock_ns += $urandom_range(step_max);
        now = clock_ns;
      end
      sel = (favour >= 0 && $urandom_range(9) < 8) ? favour : $urandom_range(3);
      send_item(($urandom_range(tick_odds - 1) == 0) ? KIND_TICK : KIND_ARRIVE, sel,
                now & TimeMax);
    end
  endtask

  // result side
  initial begin
    health_report_t got;
    int n;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = draw_gap();
      if (n > 0) begin
        pop <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      got.idx = report_index_o;
      got.st = status_e'(status_o);
      got.rs = reason_e'(reason_o);
      got.cnt = msg_count_o;
      got.age = data_age_o;
      got.err = miss_rate_o;
      got.cause = cause_sensor_o;
      got.last = last_of_run_o;
      sb.check_result(got);
    end
  end

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    mode_i = KIND_ARRIVE;
    sensor_select_i = '0;
    now_time_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_WINDOW;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: grace edge, all unknown, arrival at zero, time going back
    send_item(KIND_TICK, 0, 0);
    send_item(KIND_TICK, 3, 64'd1999999999);
    send_item(KIND_TICK, 1, 64'd2000000000);
    send_item(KIND_ARRIVE, 0, 0);
    send_item(KIND_ARRIVE, 1, 64'd2000000000);
    send_item(KIND_ARRIVE, 3, TimeMax);
    send_item(KIND_TICK, 2, 64'd2100000000);
    for (int k = 0; k < 10; k++)
      send_item(KIND_ARRIVE, 2, 64'd2100000000 + k * 64'd100000000);
    send_item(KIND_TICK, 0, 64'd3050000000);
    send_item(KIND_ARRIVE, 1, 64'd3060000000);
    send_item(KIND_TICK, 0, 64'd3090000000);
    send_item(KIND_TICK, 0, TimeMax);
    wait_drained();

    // extremes: zero window, zero period, unit period, widest values
    write_reg(CFG_WINDOW, 0);
    write_reg(CFG_HEALTHY, 256);
    write_reg(CFG_DEGRADED, 0);
    write_reg(CFG_GRACE, 0);
    write_reg(CFG_PERIOD0, 0);
    write_reg(CFG_PERIOD1, RegMax);
    write_reg(CFG_PERIOD2, 1);
    write_reg(CFG_PERIOD3, RegMax);
    clock_ns = 0;
    random_items(30, 4, 3, -1);
    wait_drained();

    // wide window with rare ticks around the widest grace time, one sensor favoured
    write_reg(CFG_WINDOW, RegMax);
    write_reg(CFG_HEALTHY, 0);
    write_reg(CFG_DEGRADED, 256);
    write_reg(CFG_GRACE, RegMax);
    write_reg(CFG_PERIOD2, $urandom_range(100, 1000));
    clock_ns = RegMax - 5000;
    random_items(90, 10, 200, 2);
    wait_drained();

    // moderate settings, most of the random traffic
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(CFG_WINDOW, $urandom_range(1000, 4000));
      write_reg(CFG_HEALTHY, $urandom_range(256));
      write_reg(CFG_DEGRADED, $urandom_range(256));
      write_reg(CFG_GRACE, $urandom_range(3000));
      write_reg(CFG_PERIOD0, $urandom_range(50, 500));
      write_reg(CFG_PERIOD1, $urandom_range(50, 500));
      write_reg(CFG_PERIOD2, $urandom_range(0, 500));
      write_reg(CFG_PERIOD3, $urandom_range(50, 500));
      random_items(23, 6, 150, -1);
      if (ph == 0) begin
        // sender holds off until every report is back
        push <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end
      random_items(23, 6, 150, -1);
      wait_drained();
    end

    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
